@@ sv/bchs_pkg.sv @@
// ----------------------------------------------------------------------------
// bchs_pkg
// shared types and constants of the blink code heartbeat sequencer
// ----------------------------------------------------------------------------
package bchs_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned REG_SEL_W = 3;

    // register indexes, byte address is 4 * index
    localparam logic [REG_SEL_W-1:0] REG_FIRST_PAUSE  = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_FLASH_ON     = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_FLASH_OFF    = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_SECOND_PAUSE = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_BEAT_ON      = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_BEAT_OFF     = 3'd5;
    localparam logic [REG_SEL_W-1:0] REG_FLASH_COUNT  = 3'd6;

    // reset values
    localparam logic [TICK_W-1:0]  RST_FIRST_PAUSE  = 16'd500;
    localparam logic [TICK_W-1:0]  RST_FLASH_ON     = 16'd200;
    localparam logic [TICK_W-1:0]  RST_FLASH_OFF    = 16'd200;
    localparam logic [TICK_W-1:0]  RST_SECOND_PAUSE = 16'd1000;
    localparam logic [TICK_W-1:0]  RST_BEAT_ON      = 16'd100;
    localparam logic [TICK_W-1:0]  RST_BEAT_OFF     = 16'd900;
    localparam logic [COUNT_W-1:0] RST_FLASH_COUNT  = 8'd0;

    typedef struct packed {
        logic [TICK_W-1:0]  first_pause_ticks;
        logic [TICK_W-1:0]  flash_on_ticks;
        logic [TICK_W-1:0]  flash_off_ticks;
        logic [TICK_W-1:0]  second_pause_ticks;
        logic [TICK_W-1:0]  beat_on_ticks;
        logic [TICK_W-1:0]  beat_off_ticks;
        logic [COUNT_W-1:0] flash_count;
    } cfg_t;

endpackage

@@ sv/bchs_if.sv @@
// ----------------------------------------------------------------------------
// bchs_if
// tick request channel and result channel of the sequencer
// ----------------------------------------------------------------------------
interface bchs_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface bchs_result_if;
    logic                            valid;
    logic                            ready;
    logic                            led_on;
    logic [bchs_pkg::PHASE_W-1:0]    phase;
    logic [bchs_pkg::COUNT_W-1:0]    flashes_left;

    modport source (output valid, output led_on, output phase, output flashes_left,
                    input ready);
    modport sink   (input valid, input led_on, input phase, input flashes_left,
                    output ready);
endinterface

@@ sv/bchs_regs.sv @@
// ----------------------------------------------------------------------------
// bchs_regs
// apb configuration registers of the sequencer
// ----------------------------------------------------------------------------
module bchs_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bchs_pkg::ADDR_W-1:0]   paddr,
    input  logic [bchs_pkg::DATA_W-1:0]   pwdata,
    output logic [bchs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output bchs_pkg::cfg_t                cfg
);

    bchs_pkg::cfg_t                   cfg_reg;
    logic [bchs_pkg::REG_SEL_W-1:0]   sel;
    logic                             wr_en;

    assign sel    = paddr[bchs_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_pause_ticks  <= bchs_pkg::RST_FIRST_PAUSE;
            cfg_reg.flash_on_ticks     <= bchs_pkg::RST_FLASH_ON;
            cfg_reg.flash_off_ticks    <= bchs_pkg::RST_FLASH_OFF;
            cfg_reg.second_pause_ticks <= bchs_pkg::RST_SECOND_PAUSE;
            cfg_reg.beat_on_ticks      <= bchs_pkg::RST_BEAT_ON;
            cfg_reg.beat_off_ticks     <= bchs_pkg::RST_BEAT_OFF;
            cfg_reg.flash_count        <= bchs_pkg::RST_FLASH_COUNT;
        end
        else if (wr_en)
        begin
            case (sel)
                bchs_pkg::REG_FIRST_PAUSE:
                    cfg_reg.first_pause_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_FLASH_ON:
                    cfg_reg.flash_on_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_FLASH_OFF:
                    cfg_reg.flash_off_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_SECOND_PAUSE:
                    cfg_reg.second_pause_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_BEAT_ON:
                    cfg_reg.beat_on_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_BEAT_OFF:
                    cfg_reg.beat_off_ticks <= pwdata[bchs_pkg::TICK_W-1:0];
                bchs_pkg::REG_FLASH_COUNT:
                    cfg_reg.flash_count <= pwdata[bchs_pkg::COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (sel)
            bchs_pkg::REG_FIRST_PAUSE:
                prdata = {16'd0, cfg_reg.first_pause_ticks};
            bchs_pkg::REG_FLASH_ON:
                prdata = {16'd0, cfg_reg.flash_on_ticks};
            bchs_pkg::REG_FLASH_OFF:
                prdata = {16'd0, cfg_reg.flash_off_ticks};
            bchs_pkg::REG_SECOND_PAUSE:
                prdata = {16'd0, cfg_reg.second_pause_ticks};
            bchs_pkg::REG_BEAT_ON:
                prdata = {16'd0, cfg_reg.beat_on_ticks};
            bchs_pkg::REG_BEAT_OFF:
                prdata = {16'd0, cfg_reg.beat_off_ticks};
            bchs_pkg::REG_FLASH_COUNT:
                prdata = {24'd0, cfg_reg.flash_count};
            default:
                prdata = '0;
        endcase
    end

endmodule

@@ sv/blink_code_heartbeat_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// blink_code_heartbeat_sequencer_unit
// status led sequencer: first pause, code flashes, second pause, heartbeat
// ----------------------------------------------------------------------------
// usage
//   tick:   one request per led tick; restart = 1 sends the sequence back to
//           its reset phase at the start of that tick
//   result: one item per request with led_on, phase and flashes_left as they
//           stand after the tick
//   apb:    seven registers at byte addresses 0..24, step 4; write them only
//           while no request is in flight
// timing
//   latency is one cycle from request to result; one request is taken in
//   every cycle, set by the single phase, counter and flash update that sits
//   between the state registers and the result register
//   the result register holds the last result while the receiver stalls and
//   tick.ready follows it: a new request is taken once the held result goes
// reset
//   rst_n clears the sequence to its reset phase with the led dark and loads
//   the registers with their default timing; no result is pending
// ----------------------------------------------------------------------------
module blink_code_heartbeat_sequencer_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bchs_pkg::ADDR_W-1:0]   paddr,
    input  logic [bchs_pkg::DATA_W-1:0]   pwdata,
    output logic [bchs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    bchs_tick_if.sink                     tick,
    bchs_result_if.source                 result
);

    typedef enum logic [bchs_pkg::PHASE_W-1:0] {
        PH_RESET     = 3'd0,
        PH_PAUSE1    = 3'd1,
        PH_FLASH_ON  = 3'd2,
        PH_FLASH_OFF = 3'd3,
        PH_PAUSE2    = 3'd4,
        PH_BEAT_ON   = 3'd5,
        PH_BEAT_OFF  = 3'd6
    } phase_t;

    bchs_pkg::cfg_t                  cfg;

    phase_t                          phase_reg, phase_next, phase_cur;
    logic [bchs_pkg::TICK_W-1:0]     ticks_reg, ticks_next, ticks_dec;
    logic [bchs_pkg::COUNT_W-1:0]    flashes_reg, flashes_next;
    logic                            led_reg, led_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            accept;
    logic                            expired;

    bchs_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign tick.ready = !out_valid_reg || result.ready;
    assign accept     = tick.valid && tick.ready;

    assign ticks_dec = ticks_reg - 16'd1;
    assign expired   = (ticks_dec == '0);
    assign phase_cur = tick.restart ? PH_RESET : phase_reg;

    always_comb
    begin
        phase_next   = phase_cur;
        ticks_next   = ticks_reg;
        flashes_next = flashes_reg;
        led_next     = led_reg;
        case (phase_cur)
            PH_RESET:
            begin
                flashes_next = cfg.flash_count;
                phase_next   = PH_PAUSE1;
                ticks_next   = cfg.first_pause_ticks;
                led_next     = 1'b0;
            end
            PH_PAUSE1:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    if (flashes_reg == '0)
                    begin
                        phase_next = PH_PAUSE2;
                        ticks_next = cfg.second_pause_ticks;
                        led_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_FLASH_ON;
                        ticks_next = cfg.flash_on_ticks;
                        led_next   = 1'b1;
                    end
                end
            end
            PH_FLASH_ON:
            begin
                if (flashes_reg == '0)
                begin
                    phase_next = PH_PAUSE2;
                    ticks_next = cfg.second_pause_ticks;
                    led_next   = 1'b0;
                end
                else
                begin
                    ticks_next = ticks_dec;
                    if (expired)
                    begin
                        flashes_next = flashes_reg - 8'd1;
                        led_next     = 1'b0;
                        if (flashes_reg == 8'd1)
                        begin
                            phase_next = PH_PAUSE2;
                            ticks_next = cfg.second_pause_ticks;
                        end
                        else
                        begin
                            phase_next = PH_FLASH_OFF;
                            ticks_next = cfg.flash_off_ticks;
                        end
                    end
                end
            end
            PH_FLASH_OFF:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_FLASH_ON;
                    ticks_next = cfg.flash_on_ticks;
                    led_next   = 1'b1;
                end
            end
            PH_PAUSE2, PH_BEAT_OFF:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_BEAT_ON;
                    ticks_next = cfg.beat_on_ticks;
                    led_next   = 1'b1;
                end
            end
            PH_BEAT_ON:
            begin
                ticks_next = ticks_dec;
                if (expired)
                begin
                    phase_next = PH_BEAT_OFF;
                    ticks_next = cfg.beat_off_ticks;
                    led_next   = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_RESET;
                led_next   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state doubles as the result register: it only moves on an accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_RESET;
            ticks_reg     <= '0;
            flashes_reg   <= '0;
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                ticks_reg   <= ticks_next;
                flashes_reg <= flashes_next;
                led_reg     <= led_next;
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.led_on       = led_reg;
    assign result.phase        = phase_reg;
    assign result.flashes_left = flashes_reg;

    a_led_only_when_lit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> (phase_reg == PH_FLASH_ON || phase_reg == PH_BEAT_ON))
        else $error("led lit outside a lit phase");

    a_restart_reports_pause1: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && tick.restart) |=> (phase_reg == PH_PAUSE1 && !led_reg && out_valid_reg))
        else $error("restart did not land in first pause");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(ticks_reg) && $stable(flashes_reg)))
        else $error("state moved without a request");

    a_flash_off_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !tick.restart && phase_reg == PH_FLASH_OFF) |=> $stable(flashes_reg))
        else $error("flash count changed in flash off");

endmodule
